// ===== hw/rtl/cle_pkg.sv =====
// ============================================================================
// Cursor line editor package
// Shared constants, payload types, command codes and memory request types.
// ============================================================================
package cle_pkg;

    localparam int LINE_MAX  = 64;
    localparam int NODE_W    = $clog2(LINE_MAX + 1);
    localparam int ADDR_W    = $clog2(LINE_MAX);
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(LINE_MAX);

    localparam logic [CFG_IDX_W-1:0] CFG_END_KEY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_KEY   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE_KEY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_KEY  = CFG_IDX_W'(3);

    localparam logic [BYTE_W-1:0] END_KEY_RST    = 8'd43;
    localparam logic [BYTE_W-1:0] HOME_KEY_RST   = 8'd45;
    localparam logic [BYTE_W-1:0] DELETE_KEY_RST = 8'd51;
    localparam logic [BYTE_W-1:0] RIGHT_KEY_RST  = 8'd42;

    typedef enum logic [2:0] {
        CMD_END,
        CMD_HOME,
        CMD_DELETE,
        CMD_RIGHT,
        CMD_INSERT
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] key_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              line_empty;
        logic              overflowed;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [NODE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_link_req;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_char_req;

    function automatic logic is_node(input logic [NODE_W-1:0] n);
        return n < NODE_W'(LINE_MAX);
    endfunction

    function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] n);
        return n[ADDR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/cle_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ============================================================================
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cle_cfg.sv =====
// ============================================================================
// Cursor line editor key registers
// Holds the four command key codes and classifies a keystroke against them.
// ============================================================================
module cle_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cle_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic [cle_pkg::BYTE_W-1:0]     i_key_byte,
    output cle_pkg::t_cmd                  o_cmd
);

    logic [cle_pkg::BYTE_W-1:0] r_end_key;
    logic [cle_pkg::BYTE_W-1:0] r_home_key;
    logic [cle_pkg::BYTE_W-1:0] r_delete_key;
    logic [cle_pkg::BYTE_W-1:0] r_right_key;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_key    <= cle_pkg::END_KEY_RST;
            r_home_key   <= cle_pkg::HOME_KEY_RST;
            r_delete_key <= cle_pkg::DELETE_KEY_RST;
            r_right_key  <= cle_pkg::RIGHT_KEY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cle_pkg::CFG_END_KEY:    r_end_key    <= i_cfg_data;
                cle_pkg::CFG_HOME_KEY:   r_home_key   <= i_cfg_data;
                cle_pkg::CFG_DELETE_KEY: r_delete_key <= i_cfg_data;
                cle_pkg::CFG_RIGHT_KEY:  r_right_key  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (i_key_byte == r_end_key) begin
            o_cmd = cle_pkg::CMD_END;
        end else if (i_key_byte == r_home_key) begin
            o_cmd = cle_pkg::CMD_HOME;
        end else if (i_key_byte == r_delete_key) begin
            o_cmd = cle_pkg::CMD_DELETE;
        end else if (i_key_byte == r_right_key) begin
            o_cmd = cle_pkg::CMD_RIGHT;
        end else begin
            o_cmd = cle_pkg::CMD_INSERT;
        end
    end

endmodule

// ===== hw/rtl/cle_seq.sv =====
// ============================================================================
// Cursor line editor sequencer
// Walks and relinks the character list through the link and character
// memories and streams the line out through a registered output stage.
// ============================================================================
module cle_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  cle_pkg::t_in_item           i_in_data,
    output logic                        o_in_stall,
    input  cle_pkg::t_cmd               i_cmd,
    output logic                        o_out_valid,
    output cle_pkg::t_out_item          o_out_data,
    input  logic                        i_out_stall,
    output cle_pkg::t_link_req          o_link_req,
    input  logic [cle_pkg::NODE_W-1:0]  i_link_rdata,
    output cle_pkg::t_char_req          o_char_req,
    input  logic [cle_pkg::BYTE_W-1:0]  i_char_rdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_END_WALK,
        S_RIGHT,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_INS_POP,
        S_INS_LINK,
        S_INS_HOOK,
        S_EMPTY,
        S_WALK_OUT
    } t_state;

    t_state                     r_state, n_state;
    logic [cle_pkg::NODE_W-1:0] r_first, n_first;
    logic [cle_pkg::NODE_W-1:0] r_prev, n_prev;
    logic [cle_pkg::NODE_W-1:0] r_after, n_after;
    logic [cle_pkg::NODE_W-1:0] r_free_head, n_free_head;
    logic [cle_pkg::NODE_W-1:0] r_fill, n_fill;
    logic [cle_pkg::NODE_W-1:0] r_count, n_count;
    logic                       r_ovf, n_ovf;
    logic [cle_pkg::NODE_W-1:0] r_node, n_node;
    logic [cle_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic                       r_out_valid, n_out_valid;
    cle_pkg::t_out_item         r_out, n_out;
    logic                       w_out_free;
    logic                       w_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last      = !cle_pkg::is_node(i_link_rdata);

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_prev      = r_prev;
        n_after     = r_after;
        n_free_head = r_free_head;
        n_fill      = r_fill;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_node      = r_node;
        n_byte      = r_byte;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_link_req  = '0;
        o_char_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.kind) begin
                        if (!cle_pkg::is_node(r_first)) begin
                            n_state = S_EMPTY;
                        end else begin
                            o_link_req.re    = 1'b1;
                            o_link_req.raddr = cle_pkg::node_addr(r_first);
                            o_char_req.re    = 1'b1;
                            o_char_req.raddr = cle_pkg::node_addr(r_first);
                            n_state          = S_WALK_OUT;
                        end
                    end else begin
                        unique case (i_cmd)
                            cle_pkg::CMD_END: begin
                                if (cle_pkg::is_node(r_after)) begin
                                    o_link_req.re    = 1'b1;
                                    o_link_req.raddr = cle_pkg::node_addr(r_after);
                                    n_node           = r_after;
                                    n_state          = S_END_WALK;
                                end
                            end
                            cle_pkg::CMD_HOME: begin
                                n_prev  = cle_pkg::NULL_NODE;
                                n_after = r_first;
                            end
                            cle_pkg::CMD_DELETE: begin
                                if (cle_pkg::is_node(r_after)) begin
                                    o_link_req.re    = 1'b1;
                                    o_link_req.raddr = cle_pkg::node_addr(r_after);
                                    n_node           = r_after;
                                    n_state          = S_DEL_UNLINK;
                                end
                            end
                            cle_pkg::CMD_RIGHT: begin
                                if (cle_pkg::is_node(r_after)) begin
                                    o_link_req.re    = 1'b1;
                                    o_link_req.raddr = cle_pkg::node_addr(r_after);
                                    n_state          = S_RIGHT;
                                end
                            end
                            cle_pkg::CMD_INSERT: begin
                                n_byte = i_in_data.key_byte;
                                if (r_count >= cle_pkg::NODE_W'(cle_pkg::LINE_MAX)) begin
                                    n_ovf = 1'b1;
                                end else if (cle_pkg::is_node(r_free_head)) begin
                                    o_link_req.re    = 1'b1;
                                    o_link_req.raddr = cle_pkg::node_addr(r_free_head);
                                    n_node           = r_free_head;
                                    n_state          = S_INS_POP;
                                end else begin
                                    n_node  = r_fill;
                                    n_fill  = r_fill + cle_pkg::NODE_W'(1);
                                    n_state = S_INS_LINK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_END_WALK: begin
                if (cle_pkg::is_node(i_link_rdata)) begin
                    o_link_req.re    = 1'b1;
                    o_link_req.raddr = cle_pkg::node_addr(i_link_rdata);
                    n_node           = i_link_rdata;
                end else begin
                    n_prev  = r_node;
                    n_after = cle_pkg::NULL_NODE;
                    n_state = S_IDLE;
                end
            end
            S_RIGHT: begin
                n_prev  = r_after;
                n_after = i_link_rdata;
                n_state = S_IDLE;
            end
            S_DEL_UNLINK: begin
                n_after = i_link_rdata;
                if (cle_pkg::is_node(r_prev)) begin
                    o_link_req.we    = 1'b1;
                    o_link_req.waddr = cle_pkg::node_addr(r_prev);
                    o_link_req.wdata = i_link_rdata;
                end else begin
                    n_first = i_link_rdata;
                end
                n_state = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = cle_pkg::node_addr(r_node);
                o_link_req.wdata = r_free_head;
                n_free_head      = r_node;
                if (r_count != '0) begin
                    n_count = r_count - cle_pkg::NODE_W'(1);
                end
                n_state = S_IDLE;
            end
            S_INS_POP: begin
                n_free_head = i_link_rdata;
                n_state     = S_INS_LINK;
            end
            S_INS_LINK: begin
                o_char_req.we    = 1'b1;
                o_char_req.waddr = cle_pkg::node_addr(r_node);
                o_char_req.wdata = r_byte;
                o_link_req.we    = 1'b1;
                o_link_req.waddr = cle_pkg::node_addr(r_node);
                o_link_req.wdata = r_after;
                n_state          = S_INS_HOOK;
            end
            S_INS_HOOK: begin
                if (cle_pkg::is_node(r_prev)) begin
                    o_link_req.we    = 1'b1;
                    o_link_req.waddr = cle_pkg::node_addr(r_prev);
                    o_link_req.wdata = r_node;
                end else begin
                    n_first = r_node;
                end
                n_prev  = r_node;
                n_count = r_count + cle_pkg::NODE_W'(1);
                n_state = S_IDLE;
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.text_byte  = '0;
                    n_out.line_empty = 1'b1;
                    n_out.overflowed = r_ovf;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_WALK_OUT: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.text_byte  = i_char_rdata;
                    n_out.line_empty = 1'b0;
                    n_out.overflowed = r_ovf;
                    n_out.last       = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_link_req.re    = 1'b1;
                        o_link_req.raddr = cle_pkg::node_addr(i_link_rdata);
                        o_char_req.re    = 1'b1;
                        o_char_req.raddr = cle_pkg::node_addr(i_link_rdata);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // The line is emptied once its final item has been loaded.
        if ((r_state == S_EMPTY || r_state == S_WALK_OUT) && n_state == S_IDLE) begin
            n_first     = cle_pkg::NULL_NODE;
            n_prev      = cle_pkg::NULL_NODE;
            n_after     = cle_pkg::NULL_NODE;
            n_free_head = cle_pkg::NULL_NODE;
            n_fill      = '0;
            n_count     = '0;
            n_ovf       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= cle_pkg::NULL_NODE;
            r_prev      <= cle_pkg::NULL_NODE;
            r_after     <= cle_pkg::NULL_NODE;
            r_free_head <= cle_pkg::NULL_NODE;
            r_fill      <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_prev      <= n_prev;
            r_after     <= n_after;
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_node <= n_node;
        r_byte <= n_byte;
        r_out  <= n_out;
    end

endmodule

// ===== hw/rtl/cursor_line_editor.sv =====
// Keystrokes other than the end key access the link memory at most once a cycle.
// The end key walks the link memory from the cursor, one node per cycle, to the line end.
// An end-of-line item streams one result per cycle after the first read, stalls permitting.
// The input is stalled until the current item's work is done; results leave via a register.
// Reset is synchronous and clears the line at once; the memories need no clearing pass.
// ============================================================================
// Cursor line editor
// Line buffer kept as a linked list in two memories, edited through a cursor.
// ============================================================================
module cursor_line_editor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  cle_pkg::t_in_item              i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output cle_pkg::t_out_item             o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cle_pkg::BYTE_W-1:0]     i_cfg_data
);

    cle_pkg::t_cmd              w_cmd;
    cle_pkg::t_link_req         w_link_req;
    cle_pkg::t_char_req         w_char_req;
    logic [cle_pkg::NODE_W-1:0] w_link_rdata;
    logic [cle_pkg::BYTE_W-1:0] w_char_rdata;

    cle_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key_byte  (i_in_data.key_byte),
        .o_cmd       (w_cmd)
    );

    cle_ram #(
        .WIDTH (cle_pkg::NODE_W),
        .DEPTH (cle_pkg::LINE_MAX)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_req.we),
        .i_waddr (w_link_req.waddr),
        .i_wdata (w_link_req.wdata),
        .i_re    (w_link_req.re),
        .i_raddr (w_link_req.raddr),
        .o_rdata (w_link_rdata)
    );

    cle_ram #(
        .WIDTH (cle_pkg::BYTE_W),
        .DEPTH (cle_pkg::LINE_MAX)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_char_req.we),
        .i_waddr (w_char_req.waddr),
        .i_wdata (w_char_req.wdata),
        .i_re    (w_char_req.re),
        .i_raddr (w_char_req.raddr),
        .o_rdata (w_char_rdata)
    );

    cle_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_cmd        (w_cmd),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .o_link_req   (w_link_req),
        .i_link_rdata (w_link_rdata),
        .o_char_req   (w_char_req),
        .i_char_rdata (w_char_rdata)
    );

endmodule

// ===== hw/rtl/cle_checker.sv =====
// ============================================================================
// Cursor line editor checker
// Port-level assertions, attached to the top level by a bind statement.
// ============================================================================
module cle_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input cle_pkg::t_in_item              i_in_data,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input cle_pkg::t_out_item             o_out_data,
    input logic                           i_out_stall
);

    a_eol_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.kind) |=> o_in_stall)
        else $error("Input was not stalled after an end-of-line item.");

    a_key_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_in_data.kind && !o_out_valid) |=> !o_out_valid)
        else $error("A keystroke item produced a result.");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.line_empty) |->
            (o_out_data.last && o_out_data.text_byte == '0))
        else $error("An empty-line result is not a lone zero item.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("A stalled result item changed or was dropped.");

endmodule

bind cursor_line_editor cle_checker u_checker (.*);
